// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, request and status codes, channel words.
// No dependencies.
`default_nettype none
package spq_pkg;
  localparam int Capacity = 16;
  localparam int CntW = $clog2(Capacity + 1);
  localparam int IdxW = $clog2(Capacity);

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_MODIFY  = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    req_t        req_type;
    logic [31:0] item_value;
    logic [15:0] item_priority;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] taken_value;
    logic [31:0] head_value;
    logic [15:0] head_priority;
    logic        is_empty;
    logic [4:0]  entry_total;
  } response_t;

  typedef struct packed {
    logic load;
    logic do_insert;
    logic do_remove;
    logic do_clear;
  } spq_cmd_t;

  typedef struct packed {
    logic             found;
    logic             full;
    logic             empty;
    logic [IdxW-1:0]  match_idx;
  } spq_stat_t;
endpackage
`default_nettype wire

// ===== rtl/spq_if.sv =====
// Valid/ready channel interface carrying one word of a generic payload.
// Depends on nothing.
`default_nettype none
interface spq_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/spq_datapath.sv =====
// Datapath: row of sorted cells with parallel compare, shift insert and remove.
// Depends on spq_pkg.
`default_nettype none
module spq_datapath
  import spq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spq_cmd_t           cmd,
  input  wire logic signed [31:0] in_value,
  input  wire logic signed [15:0] in_priority,
  input  wire logic [IdxW-1:0]    remove_idx,
  output spq_stat_t               stat,
  output logic signed [31:0]      head_value,
  output logic signed [15:0]      head_priority,
  output logic [CntW-1:0]         count
);
  logic signed [31:0] cval [Capacity];
  logic signed [15:0] cpri [Capacity];
  logic signed [31:0] rval;
  logic signed [15:0] rpri;
  logic [Capacity-1:0] vld, ge, hit;
  logic [IdxW-1:0] midx;

  always_comb begin
    midx = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      vld[i] = CntW'(i) < count;
      ge[i]  = vld[i] && (cpri[i] >= rpri);
      hit[i] = vld[i] && (cval[i] == rval);
      if (hit[i]) begin
        midx = IdxW'(i);
      end
    end
  end

  assign stat.found     = |hit;
  assign stat.match_idx = midx;
  assign stat.full      = count == CntW'(Capacity);
  assign stat.empty     = count == '0;
  assign head_value     = cval[0];
  assign head_priority  = cpri[0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rval <= in_value;
      rpri <= in_priority;
    end
    if (cmd.do_remove) begin
      for (int i = 0; i < Capacity - 1; i++) begin
        if (IdxW'(i) >= remove_idx) begin
          cval[i] <= cval[i+1];
          cpri[i] <= cpri[i+1];
        end
      end
    end else if (cmd.do_insert) begin
      for (int i = 0; i < Capacity; i++) begin
        if (!ge[i]) begin
          if (i == 0 || ge[(i == 0) ? 0 : i-1]) begin
            cval[i] <= rval;
            cpri[i] <= rpri;
          end else begin
            cval[i] <= cval[(i == 0) ? 0 : i-1];
            cpri[i] <= cpri[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.do_clear) begin
      count <= '0;
    end else if (cmd.do_remove) begin
      count <= count - CntW'(1);
    end else if (cmd.do_insert) begin
      count <= count + CntW'(1);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CntW'(Capacity))
    else $error("count above capacity");
  assert property (@(posedge clk) disable iff (rst)
      cmd.do_insert && !cmd.do_remove |-> !stat.full)
    else $error("insert into full queue");
  assert property (@(posedge clk) disable iff (rst)
      cmd.do_remove |-> !stat.empty)
    else $error("remove from empty queue");
endmodule
`default_nettype wire

// ===== rtl/spq_ctrl.sv =====
// Controller: sequences each request over the cell datapath and builds the result.
// Depends on spq_pkg.
`default_nettype none
module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_req,
  output spq_cmd_t                cmd,
  output logic [IdxW-1:0]         remove_idx,
  input  wire spq_stat_t          stat,
  input  wire logic signed [31:0] head_value,
  input  wire logic signed [15:0] head_priority,
  input  wire logic [CntW-1:0]    count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic signed [31:0]      taken_value,
  output logic signed [31:0]      out_head_value,
  output logic signed [15:0]      out_head_priority,
  output logic                    is_empty,
  output logic [4:0]              entry_total
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_REINS, S_REPORT} state_t;
  state_t state;
  req_t req;
  status_t st;
  logic signed [31:0] taken;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    remove_idx = '0;
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_EXEC: begin
        unique case (req)
          REQ_INSERT:  cmd.do_insert = !stat.full;
          REQ_EXTRACT: cmd.do_remove = !stat.empty;
          REQ_MODIFY: begin
            cmd.do_remove = stat.found;
            remove_idx = stat.match_idx;
          end
          REQ_CLEAR:   cmd.do_clear = 1'b1;
          default: ;
        endcase
      end
      S_REINS: cmd.do_insert = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_REPORT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= req_t'(in_req);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          st <= ST_OK;
          taken <= '0;
          state <= S_REPORT;
          unique case (req)
            REQ_INSERT:  if (stat.full) st <= ST_FULL;
            REQ_EXTRACT: begin
              if (stat.empty) st <= ST_EMPTY;
              else taken <= head_value;
            end
            REQ_MODIFY: begin
              if (!stat.found) st <= ST_NOT_FOUND;
              else state <= S_REINS;
            end
            default: ;
          endcase
        end
        S_REINS: state <= S_REPORT;
        S_REPORT: begin
          if (!out_valid || out_ready) begin
            status <= st;
            taken_value <= taken;
            is_empty <= stat.empty;
            out_head_value <= stat.empty ? 32'sd0 : head_value;
            out_head_priority <= stat.empty ? 16'sd0 : head_priority;
            entry_total <= 5'(count);
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      (state == S_REPORT) |=> out_valid)
    else $error("result not raised after report");
  assert property (@(posedge clk) disable iff (rst)
      (state == S_REINS) |-> $past(state) == S_EXEC && req == REQ_MODIFY)
    else $error("reinsert outside modify");
  assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(status) && $stable(taken_value))
    else $error("result changed while waiting");
endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue_unit.sv =====
// Sorted priority queue top level: controller plus cell datapath.
// Each accepted word goes through an execute step (plus a reinsert step for modify with
// a match) and a report step that registers the result; no new word is accepted until
// the report step is done, and a waiting result holds the next word in its report step.
// Reset (rst, synchronous): queue empty, no result pending.
// Depends on spq_pkg, spq_if, spq_ctrl, spq_datapath.
`default_nettype none
module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  spq_if.sink       req,
  spq_if.source     rsp
);
  spq_cmd_t cmd;
  spq_stat_t stat;
  logic [IdxW-1:0] remove_idx;
  logic signed [31:0] hv;
  logic signed [15:0] hp;
  logic [CntW-1:0] count;

  spq_datapath u_dp (
    .clk, .rst, .cmd,
    .in_value(req.data.item_value), .in_priority(req.data.item_priority),
    .remove_idx, .stat, .head_value(hv), .head_priority(hp), .count
  );

  spq_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready), .in_req(req.data.req_type),
    .cmd, .remove_idx, .stat, .head_value(hv), .head_priority(hp), .count,
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .status(rsp.data.status), .taken_value(rsp.data.taken_value),
    .out_head_value(rsp.data.head_value), .out_head_priority(rsp.data.head_priority),
    .is_empty(rsp.data.is_empty), .entry_total(rsp.data.entry_total)
  );
endmodule
`default_nettype wire

// ===== test/tb_sorted_priority_queue_unit.sv =====
// Testbench for sorted_priority_queue_unit: drives request words, predicts
// each response word from a queue model of its own, and checks it field by field.
// Depends on spq_pkg, spq_if and the unit itself.
`timescale 1ns / 1ps
module tb_sorted_priority_queue_unit
  import spq_pkg::*;
();

  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  spq_if #(.payload_t(request_t))  req (clk);
  spq_if #(.payload_t(response_t)) rsp (clk);

  sorted_priority_queue_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  logic [31:0]        q_val [Capacity];
  logic signed [15:0] q_pri [Capacity];
  int                 q_count;
  response_t          pending_q[$];
  logic [31:0]        value_pool[8];
  bit                 failed = 1'b0;
  bit                 quiet;
  int                 next_gap;
  int                 cycles = 0;

  function automatic int draw_wait();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic void queue_place(logic [31:0] v, logic signed [15:0] p);
    int pos;
    pos = 0;
    while (pos < q_count && q_pri[pos] >= p) pos++;
    for (int i = q_count; i > pos; i--) begin
      q_val[i] = q_val[i-1];
      q_pri[i] = q_pri[i-1];
    end
    q_val[pos] = v;
    q_pri[pos] = p;
    q_count++;
  endfunction

  function automatic void queue_take(int pos);
    for (int i = pos; i + 1 < q_count; i++) begin
      q_val[i] = q_val[i+1];
      q_pri[i] = q_pri[i+1];
    end
    q_count--;
  endfunction

  function automatic response_t queue_response(request_t w);
    response_t r;
    int        hit;
    r = '0;
    r.status = ST_OK;
    case (w.req_type)
      REQ_INSERT: begin
        if (q_count >= Capacity) r.status = ST_FULL;
        else queue_place(w.item_value, w.item_priority);
      end
      REQ_EXTRACT: begin
        if (q_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.taken_value = q_val[0];
          queue_take(0);
        end
      end
      REQ_MODIFY: begin
        hit = -1;
        for (int i = q_count - 1; i >= 0; i--)
          if (q_val[i] == w.item_value) hit = i;
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          queue_take(hit);
          queue_place(w.item_value, w.item_priority);
        end
      end
      default: q_count = 0;
    endcase
    r.is_empty = (q_count == 0);
    if (q_count != 0) begin
      r.head_value = q_val[0];
      r.head_priority = q_pri[0];
    end
    r.entry_total = q_count[4:0];
    return r;
  endfunction

  task automatic send_word(req_t t, logic [31:0] v, logic [15:0] p);
    request_t w;
    w = '{req_type: t, item_value: v, item_priority: p};
    repeat (next_gap) @(posedge clk);
    req.valid <= 1'b1;
    req.data <= w;
    do @(posedge clk); while (!req.ready);
    pending_q.push_back(queue_response(w));
    next_gap = draw_wait();
    if (next_gap > 0) req.valid <= 1'b0;
  endtask

  task automatic drop_valid();
    if (next_gap == 0) begin
      req.valid <= 1'b0;
      next_gap = 1;
    end
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  int stall;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected response %p", $time, rsp.data);
          failed = 1'b1;
        end else begin
          response_t e;
          e = pending_q.pop_front();
          if (rsp.data.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.data.status);
            failed = 1'b1;
          end
          if (rsp.data.taken_value !== e.taken_value) begin
            $display("%0t: taken_value expected %h actual %h", $time, e.taken_value,
                     rsp.data.taken_value);
            failed = 1'b1;
          end
          if (rsp.data.head_value !== e.head_value) begin
            $display("%0t: head_value expected %h actual %h", $time, e.head_value,
                     rsp.data.head_value);
            failed = 1'b1;
          end
          if (rsp.data.head_priority !== e.head_priority) begin
            $display("%0t: head_priority expected %h actual %h", $time, e.head_priority,
                     rsp.data.head_priority);
            failed = 1'b1;
          end
          if (rsp.data.is_empty !== e.is_empty) begin
            $display("%0t: is_empty expected %b actual %b", $time, e.is_empty,
                     rsp.data.is_empty);
            failed = 1'b1;
          end
          if (rsp.data.entry_total !== e.entry_total) begin
            $display("%0t: entry_total expected %0d actual %0d", $time, e.entry_total,
                     rsp.data.entry_total);
            failed = 1'b1;
          end
        end
        stall = draw_wait();
      end else if (stall > 0) begin
        stall--;
      end
      rsp.ready <= (stall == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_empty_cases();
    send_word(REQ_EXTRACT, 32'h0, 16'h0);
    send_word(REQ_MODIFY, value_pool[0], 16'h0);
  endtask

  task automatic test_fill_and_order();
    logic [15:0] pri_set[4];
    pri_set = '{16'h8000, 16'h7fff, 16'h0000, 16'h7fff};
    send_word(REQ_INSERT, 32'h8000_0000, 16'h8000);
    send_word(REQ_INSERT, 32'h7fff_ffff, 16'h7fff);
    send_word(REQ_INSERT, 32'hffff_ffff, 16'hffff);
    send_word(REQ_INSERT, 32'h0000_0000, 16'h7fff);
    for (int i = 0; i < 12; i++)
      send_word(REQ_INSERT, value_pool[i % 8], pri_set[i % 4]);
    send_word(REQ_INSERT, 32'h1234_5678, 16'h7fff);
    send_word(REQ_MODIFY, 32'h8000_0000, 16'h7fff);
    send_word(REQ_MODIFY, 32'h5555_aaaa, 16'h0001);
    send_word(REQ_EXTRACT, 32'h0, 16'h0);
    send_word(REQ_EXTRACT, 32'h0, 16'h0);
    send_word(REQ_CLEAR, 32'hffff_ffff, 16'hffff);
  endtask

  task automatic test_random(int count);
    logic [31:0] v;
    logic [15:0] p;
    int          pick;
    for (int n = 0; n < count; n++) begin
      v = ($urandom_range(0, 3) == 0) ? $urandom() : value_pool[$urandom_range(0, 7)];
      p = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 5) - 2);
      pick = $urandom_range(0, 99);
      if (pick < 45) send_word(REQ_INSERT, v, p);
      else if (pick < 75) send_word(REQ_EXTRACT, v, p);
      else if (pick < 98) send_word(REQ_MODIFY, v, p);
      else send_word(REQ_CLEAR, v, p);
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    quiet = 1'b0;
    next_gap = 0;
    q_count = 0;
    for (int i = 0; i < 8; i++) value_pool[i] = $urandom();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_cases();
    test_fill_and_order();
    wait_drained();
    quiet = 1'b1;
    test_random(200);
    quiet = 1'b0;
    test_random(400);
    wait_drained();
    test_random(525);
    wait_drained();
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
